FILE: rtl/sjfq_pkg.sv
`timescale 1ns / 1ps
package sjfq_pkg;

  // input command codes
  localparam logic CMD_ARRIVE = 1'b0;
  localparam logic CMD_DONE   = 1'b1;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_DROPPED = 2'd1;
  localparam logic [1:0] ST_IDLE    = 2'd2;

  typedef struct packed {
    logic [31:0] svc_time;
    logic [15:0] tag;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_CMP,
    S_INS_LAST,
    S_POP_HEAD,
    S_POP_SH,
    S_DONE
  } state_t;

endpackage

FILE: rtl/sjfq_mem.sv
`timescale 1ns / 1ps
module sjfq_mem import sjfq_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  entry_t                   wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output entry_t                   rdata
);

  entry_t mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/shortest_job_first_queue_server.sv
`timescale 1ns / 1ps
// channel  direction  ports
// in       input      in_valid, in_ready, in_cmd, in_job_tag, in_service_time
// out      output     out_valid, out_ready, out_started .. out_status
//
// one item at a time; an arrival or completion with nothing stored goes straight to the result
// insert into the store: the k larger entries are shifted up one slot each
// completion with n stored: the head enters service and the store is shifted down one slot
// a cycle through the single memory read port
// synchronous reset clears count and busy; no clearing pass on the store
// the result register holds while out_valid is high and out_ready is low; the next item is taken
// as soon as the result has been loaded
module shortest_job_first_queue_server import sjfq_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_cmd,
  input  logic [15:0] in_job_tag,
  input  logic [31:0] in_service_time,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_started,
  output logic [15:0] out_start_tag,
  output logic [31:0] out_start_time,
  output logic        out_finished,
  output logic [15:0] out_finished_tag,
  output logic        out_server_busy,
  output logic [4:0]  out_waiting_count,
  output logic [1:0]  out_status
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  logic busy_r, busy_nxt;
  logic [15:0] serv_r, serv_nxt;
  entry_t new_r, new_nxt;
  logic res_st_r, res_st_nxt, res_fin_r, res_fin_nxt;
  logic [15:0] res_stag_r, res_stag_nxt, res_ftag_r, res_ftag_nxt;
  logic [31:0] res_stime_r, res_stime_nxt;
  logic [1:0] res_status_r, res_status_nxt;
  logic out_valid_r;
  logic mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  entry_t mem_wdata, mem_rdata;
  logic in_acc, out_load;

  sjfq_mem #(.DEPTH(QUEUE_DEPTH)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ready);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_DONE;
          if (busy_r && in_cmd == CMD_ARRIVE && cnt_r != '0
              && cnt_r < CW'(QUEUE_DEPTH)) begin
            state_nxt = S_INS_CMP;
          end else if (busy_r && in_cmd == CMD_DONE && cnt_r != '0) begin
            state_nxt = S_POP_HEAD;
          end
        end
      end
      S_INS_CMP: begin
        if (mem_rdata.svc_time > new_r.svc_time) begin
          state_nxt = (pos_r == AW'(1)) ? S_INS_LAST : S_INS_CMP;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_INS_LAST: state_nxt = S_DONE;
      S_POP_HEAD: state_nxt = (cnt_r == CW'(1)) ? S_DONE : S_POP_SH;
      S_POP_SH: begin
        if ((CW'(pos_r) + CW'(1)) >= cnt_r) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    cnt_nxt        = cnt_r;
    pos_nxt        = pos_r;
    busy_nxt       = busy_r;
    serv_nxt       = serv_r;
    new_nxt        = new_r;
    res_st_nxt     = res_st_r;
    res_fin_nxt    = res_fin_r;
    res_stag_nxt   = res_stag_r;
    res_ftag_nxt   = res_ftag_r;
    res_stime_nxt  = res_stime_r;
    res_status_nxt = res_status_r;
    mem_we         = 1'b0;
    mem_waddr      = pos_r;
    mem_wdata      = new_r;
    mem_raddr      = pos_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          new_nxt.tag      = in_job_tag;
          new_nxt.svc_time = in_service_time;
          res_st_nxt       = 1'b0;
          res_fin_nxt      = 1'b0;
          res_stag_nxt     = '0;
          res_ftag_nxt     = '0;
          res_stime_nxt    = '0;
          res_status_nxt   = ST_OK;
          pos_nxt          = cnt_r[AW-1:0];
          if (in_cmd == CMD_ARRIVE) begin
            if (!busy_r) begin
              busy_nxt      = 1'b1;
              serv_nxt      = in_job_tag;
              res_st_nxt    = 1'b1;
              res_stag_nxt  = in_job_tag;
              res_stime_nxt = in_service_time;
            end else if (cnt_r >= CW'(QUEUE_DEPTH)) begin
              res_status_nxt = ST_DROPPED;
            end else if (cnt_r == '0) begin
              // empty store: write straight to the head
              mem_we              = 1'b1;
              mem_waddr           = '0;
              mem_wdata.tag       = in_job_tag;
              mem_wdata.svc_time  = in_service_time;
              cnt_nxt             = cnt_r + CW'(1);
            end else begin
              mem_raddr = AW'(cnt_r - CW'(1));
            end
          end else begin
            if (!busy_r) begin
              res_status_nxt = ST_IDLE;
            end else begin
              res_fin_nxt  = 1'b1;
              res_ftag_nxt = serv_r;
              if (cnt_r == '0) begin
                busy_nxt = 1'b0;
              end else begin
                mem_raddr = '0;
              end
            end
          end
        end
      end
      // shift larger entries up until the slot is found
      S_INS_CMP: begin
        mem_we = 1'b1;
        if (mem_rdata.svc_time > new_r.svc_time) begin
          mem_wdata = mem_rdata;
          pos_nxt   = pos_r - AW'(1);
          mem_raddr = pos_r - AW'(2);
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      S_INS_LAST: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        cnt_nxt   = cnt_r + CW'(1);
      end
      // head enters service, then the rest moves down one slot
      S_POP_HEAD: begin
        serv_nxt      = mem_rdata.tag;
        res_st_nxt    = 1'b1;
        res_stag_nxt  = mem_rdata.tag;
        res_stime_nxt = mem_rdata.svc_time;
        pos_nxt       = AW'(1);
        mem_raddr     = AW'(1);
        if (cnt_r == CW'(1)) begin
          cnt_nxt = '0;
        end
      end
      S_POP_SH: begin
        mem_we    = 1'b1;
        mem_waddr = pos_r - AW'(1);
        mem_wdata = mem_rdata;
        if ((CW'(pos_r) + CW'(1)) < cnt_r) begin
          pos_nxt   = pos_r + AW'(1);
          mem_raddr = pos_r + AW'(1);
        end else begin
          cnt_nxt = cnt_r - CW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      busy_r      <= 1'b0;
      serv_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      busy_r  <= busy_nxt;
      serv_r  <= serv_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // working payload
  always_ff @(posedge clk) begin
    pos_r        <= pos_nxt;
    new_r        <= new_nxt;
    res_st_r     <= res_st_nxt;
    res_fin_r    <= res_fin_nxt;
    res_stag_r   <= res_stag_nxt;
    res_ftag_r   <= res_ftag_nxt;
    res_stime_r  <= res_stime_nxt;
    res_status_r <= res_status_nxt;
  end

  // result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_started       <= res_st_r;
      out_start_tag     <= res_stag_r;
      out_start_time    <= res_stime_r;
      out_finished      <= res_fin_r;
      out_finished_tag  <= res_ftag_r;
      out_server_busy   <= busy_r;
      out_waiting_count <= 5'(cnt_r);
      out_status        <= res_status_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule
